### rtl/mks_pkg.sv
// Shared types, phase codes and key table for the matrix keypad scanner.
package mks_pkg;

    typedef logic [2:0]  phase_t;
    typedef logic [1:0]  row_t;
    typedef logic [3:0]  key_t;
    typedef logic [15:0] ticks_t;

    localparam phase_t PH_IDLE     = 3'd0;
    localparam phase_t PH_DEBOUNCE = 3'd1;
    localparam phase_t PH_DECODE   = 3'd2;
    localparam phase_t PH_RELEASE  = 3'd3;

    localparam logic [3:0] ALL_ROWS       = 4'hf;
    localparam ticks_t     DEBOUNCE_RESET = 16'd2;
    localparam row_t       ROW_FIRST      = 2'd3;
    localparam row_t       ROW_LAST       = 2'd0;

    // Column index: 0 = A5, 1 = A6, 2 = A7.
    function automatic key_t key_lookup(input row_t row, input logic [1:0] col);
        key_t code;
        begin
            code = 4'd0;
            case ({row, col})
                4'b00_00: code = 4'd2;
                4'b00_01: code = 4'd1;
                4'b00_10: code = 4'd3;
                4'b01_00: code = 4'd0;
                4'b01_01: code = 4'd11;
                4'b01_10: code = 4'd12;
                4'b10_00: code = 4'd8;
                4'b10_01: code = 4'd7;
                4'b10_10: code = 4'd9;
                4'b11_00: code = 4'd5;
                4'b11_01: code = 4'd4;
                4'b11_10: code = 4'd6;
                default:  code = 4'd0;
            endcase
            return code;
        end
    endfunction

    function automatic logic [3:0] row_onehot(input row_t row);
        return 4'b0001 << row;
    endfunction

endpackage

### rtl/matrix_keypad_scanner_unit.sv
// Matrix keypad scanner top level: 4x3 key matrix scan with debounce and release wait.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  sample   | sample_valid/sample_stall  | column_bits[2:0]
//  result   | result_valid/result_stall  | row_drive, scan_done, key_found, key_code
//  cfg      | cfg_valid/cfg_ready        | cfg_data[15:0] (debounce_ticks)
//
// One request per cycle unless stalled; each sample yields exactly one result.
// Scan state updates as the sample is taken; the result register holds the outputs.
// A sample is taken whenever the result register is empty or being drained.
// Reset: idle, row 3, debounce_ticks = 2, result register empty.
module matrix_keypad_scanner_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  logic [2:0]           column_bits,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [3:0]           row_drive,
    output logic                 scan_done,
    output logic                 key_found,
    output logic [3:0]           key_code,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  mks_pkg::ticks_t      cfg_data
);
    import mks_pkg::*;

    ticks_t debounce_reg;
    phase_t phase_reg, phase_next;
    row_t   row_reg, row_next;
    ticks_t wait_reg, wait_next;
    key_t   held_reg, held_next;
    logic   valid_code_reg, valid_code_next;

    logic       out_valid_reg;
    logic [3:0] drive_reg, drive_next;
    logic       done_reg, done_next;
    logic       found_reg, found_next;
    key_t       code_reg, code_next;

    logic take;
    logic advance;

    assign sample_stall = out_valid_reg & result_stall;
    assign take         = sample_valid & ~sample_stall;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        phase_next      = phase_reg;
        row_next        = row_reg;
        wait_next       = wait_reg;
        held_next       = held_reg;
        valid_code_next = valid_code_reg;
        drive_next      = ALL_ROWS;
        done_next       = 1'b0;
        found_next      = 1'b0;
        code_next       = 4'd0;
        advance         = 1'b0;

        case (phase_reg)
            PH_DEBOUNCE:
            begin
                if (wait_reg != 16'd0)
                begin
                    wait_next = wait_reg - 16'd1;
                end
                else if (column_bits == 3'd0)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next      = PH_DECODE;
                    row_next        = ROW_FIRST;
                    held_next       = 4'd0;
                    valid_code_next = 1'b0;
                    drive_next      = row_onehot(ROW_FIRST);
                end
            end
            PH_DECODE:
            begin
                if (column_bits inside {3'd1, 3'd2, 3'd4})
                begin
                    held_next       = key_lookup(row_reg, {column_bits[2], column_bits[1]});
                    valid_code_next = 1'b1;
                end
                if (column_bits == 3'd0)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    phase_next = PH_RELEASE;
                    drive_next = row_onehot(row_reg);
                end
            end
            PH_RELEASE:
            begin
                if (column_bits == 3'd0)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    drive_next = row_onehot(row_reg);
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (column_bits != 3'd0)
                begin
                    phase_next = PH_DEBOUNCE;
                    wait_next  = debounce_reg;
                end
            end
        endcase

        if (advance)
        begin
            if (row_reg == ROW_LAST)
            begin
                done_next  = 1'b1;
                found_next = valid_code_next;
                code_next  = valid_code_next ? held_next : 4'd0;
                phase_next = PH_IDLE;
                row_next   = ROW_FIRST;
                drive_next = ALL_ROWS;
            end
            else
            begin
                row_next   = row_reg - 2'd1;
                phase_next = PH_DECODE;
                drive_next = row_onehot(row_reg - 2'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            phase_reg      <= PH_IDLE;
            row_reg        <= ROW_FIRST;
            wait_reg       <= 16'd0;
            held_reg       <= 4'd0;
            valid_code_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                debounce_reg <= cfg_data;
            end
            if (take)
            begin
                phase_reg      <= phase_next;
                row_reg        <= row_next;
                wait_reg       <= wait_next;
                held_reg       <= held_next;
                valid_code_reg <= valid_code_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            drive_reg <= drive_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            code_reg  <= code_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign row_drive    = drive_reg;
    assign scan_done    = done_reg;
    assign key_found    = found_reg;
    assign key_code     = code_reg;

endmodule

### tb/tb_matrix_keypad_scanner_unit.sv
// Testbench for the keypad scanner: keypad-driven and directed column streams, checked per result.
`timescale 1ns / 100ps

module tb_matrix_keypad_scanner_unit;

    import mks_pkg::*;

    typedef struct packed {
        logic [3:0] rows;
        logic       done;
        logic       found;
        key_t       code;
    } scan_result_t;

    // Key per (row, column), index row*3 + col, col 0 = A5.
    localparam logic [47:0] KEY_MAP = {4'd6, 4'd4, 4'd5, 4'd9, 4'd7, 4'd8,
                                       4'd12, 4'd11, 4'd0, 4'd3, 4'd1, 4'd2};
    localparam int LONG_HOLD_CYCLES = 150;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       sample_valid = 1'b0;
    logic       sample_stall;
    logic [2:0] column_bits  = 3'd0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [3:0] row_drive;
    logic       scan_done;
    logic       key_found;
    logic [3:0] key_code;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    ticks_t     cfg_data     = '0;

    // scanner state as predicted
    phase_t scan_phase    = PH_IDLE;
    row_t   scan_row      = ROW_FIRST;
    ticks_t debounce_left = '0;
    key_t   held_key      = '0;
    logic   key_seen      = 1'b0;
    ticks_t debounce_cfg  = DEBOUNCE_RESET;

    scan_result_t pending_scans[$];
    scan_result_t oldest_scan;
    logic [3:0]   last_rows  = ALL_ROWS;
    logic [11:0]  keys_down  = '0;
    int           burst_left = 0;
    int           items_sent = 0;
    int           mismatches = 0;
    logic         hold_req   = 1'b0;
    int           hold_left  = 0;
    int           stall_mode = 0;
    int           mode_left  = 0;

    matrix_keypad_scanner_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .column_bits  (column_bits),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .row_drive    (row_drive),
        .scan_done    (scan_done),
        .key_found    (key_found),
        .key_code     (key_code),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic scan_result_t predict_scan(input logic [2:0] cols);
        scan_result_t res;
        logic         advance;
        logic [1:0]   col;
        res      = '0;
        res.rows = ALL_ROWS;
        advance  = 1'b0;
        case (scan_phase)
            PH_DEBOUNCE:
            begin
                if (debounce_left != 0)
                    debounce_left = debounce_left - 1'b1;
                else if (cols == 3'd0)
                    scan_phase = PH_IDLE;
                else
                begin
                    scan_phase = PH_DECODE;
                    scan_row   = ROW_FIRST;
                    held_key   = '0;
                    key_seen   = 1'b0;
                    res.rows   = 4'b0001 << scan_row;
                end
            end
            PH_DECODE:
            begin
                if (cols == 3'b001 || cols == 3'b010 || cols == 3'b100)
                begin
                    col      = cols[2] ? 2'd2 : (cols[1] ? 2'd1 : 2'd0);
                    held_key = KEY_MAP[(scan_row * 3 + col) * 4 +: 4];
                    key_seen = 1'b1;
                end
                if (cols == 3'd0)
                    advance = 1'b1;
                else
                begin
                    scan_phase = PH_RELEASE;
                    res.rows   = 4'b0001 << scan_row;
                end
            end
            PH_RELEASE:
            begin
                if (cols == 3'd0)
                    advance = 1'b1;
                else
                    res.rows = 4'b0001 << scan_row;
            end
            default:
            begin
                scan_phase = PH_IDLE;
                if (cols != 3'd0)
                begin
                    scan_phase    = PH_DEBOUNCE;
                    debounce_left = debounce_cfg;
                end
            end
        endcase
        if (advance)
        begin
            if (scan_row == ROW_LAST)
            begin
                res.done   = 1'b1;
                res.found  = key_seen;
                res.code   = key_seen ? held_key : key_t'(0);
                scan_phase = PH_IDLE;
                scan_row   = ROW_FIRST;
                res.rows   = ALL_ROWS;
            end
            else
            begin
                scan_row   = scan_row - 1'b1;
                scan_phase = PH_DECODE;
                res.rows   = 4'b0001 << scan_row;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic drive_columns(input logic [2:0] cols);
        int           gap;
        scan_result_t next_scan;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 32);
        end
        sample_valid <= 1'b1;
        column_bits  <= cols;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        next_scan = predict_scan(cols);
        pending_scans.push_back(next_scan);
        last_rows = next_scan.rows;
        burst_left--;
        items_sent++;
    endtask

    // column lines as a keypad would return them for the last row drive, with some bounce
    task automatic send_sensed();
        logic [2:0] cols;
        int         r;
        cols = '0;
        for (r = 0; r < 4; r++)
            if (last_rows[r])
                cols = cols | keys_down[r * 3 +: 3];
        if ($urandom_range(0, 15) == 0)
            cols = 3'($urandom_range(0, 7));
        drive_columns(cols);
    endtask

    task automatic write_debounce(input ticks_t ticks);
        sample_valid <= 1'b0;
        burst_left = 0;
        while (pending_scans.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        debounce_cfg = ticks;
    endtask

    task automatic key_press_session();
        int          pick;
        int          hold;
        logic [11:0] keys;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            keys = 12'd1 << $urandom_range(0, 11);
        else if (pick < 85)
            keys = (12'd1 << $urandom_range(0, 11)) | (12'd1 << $urandom_range(0, 11));
        else
            keys = 12'($urandom);
        repeat ($urandom_range(0, 3)) send_sensed();
        keys_down = keys;
        hold = (pick >= 95) ? $urandom_range(0, debounce_cfg)
                            : debounce_cfg + $urandom_range(1, 16);
        repeat (hold) send_sensed();
        keys_down = '0;
        while (scan_phase != PH_IDLE) send_sensed();
    endtask

    task automatic test_reset_debounce();
        drive_columns(3'd0);
        drive_columns(3'b100);
        drive_columns(3'b101);
        drive_columns(3'b010);
        drive_columns(3'b100);
        drive_columns(3'd0);
        drive_columns(3'd0);
        drive_columns(3'd0);
        drive_columns(3'b100);
        drive_columns(3'd0);
    endtask

    task automatic test_directed_scans();
        write_debounce(16'd0);
        // all columns at press, single key, multi-column keeps code, immediate release
        drive_columns(3'b111);
        drive_columns(3'b111);
        drive_columns(3'b010);
        drive_columns(3'd0);
        drive_columns(3'd0);
        drive_columns(3'b010);
        drive_columns(3'd0);
        drive_columns(3'b110);
        drive_columns(3'b011);
        drive_columns(3'd0);
        // bounce: clear at recheck, back to idle with nothing reported
        drive_columns(3'b001);
        drive_columns(3'd0);
        // scan with nothing decoded
        drive_columns(3'b100);
        drive_columns(3'b100);
        drive_columns(3'd0);
        drive_columns(3'd0);
        drive_columns(3'd0);
        drive_columns(3'd0);
    endtask

    task automatic test_random_scans();
        ticks_t settings [6];
        int     k;
        int     stop_at;
        settings = '{16'd1, 16'd3, 16'd0, 16'd2, 16'd5, 16'd7};
        for (k = 0; k < 6; k++)
        begin
            write_debounce(settings[k]);
            stop_at = items_sent + 160;
            while (items_sent < stop_at) key_press_session();
        end
    endtask

    task automatic test_input_backpressure();
        write_debounce(16'd2);
        hold_req   = 1'b1;
        burst_left = 400;
        repeat (5) key_press_session();
    endtask

    task automatic test_long_debounce();
        write_debounce(16'd300);
        drive_columns(3'b001);
        repeat (300) drive_columns(3'($urandom_range(0, 7)));
        drive_columns(3'b001);
        drive_columns(3'b001);
        drive_columns(3'd0);
        drive_columns(3'd0);
        drive_columns(3'd0);
        drive_columns(3'd0);
    endtask

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = LONG_HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(32, 256);
            end
            else
                mode_left--;
            case (stall_mode)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 99) < 30);
                2:       result_stall <= ($urandom_range(0, 99) < 75);
                default: result_stall <= ~result_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_scans.size() == 0)
                report_mismatch("unexpected result, row_drive", row_drive, 0);
            else
            begin
                oldest_scan = pending_scans.pop_front();
                if (row_drive !== oldest_scan.rows)
                    report_mismatch("row_drive", row_drive, oldest_scan.rows);
                if (scan_done !== oldest_scan.done)
                    report_mismatch("scan_done", scan_done, oldest_scan.done);
                if (key_found !== oldest_scan.found)
                    report_mismatch("key_found", key_found, oldest_scan.found);
                if (key_code !== oldest_scan.code)
                    report_mismatch("key_code", key_code, oldest_scan.code);
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_debounce();
        test_directed_scans();
        test_random_scans();
        test_input_backpressure();
        test_long_debounce();
        sample_valid <= 1'b0;
        while (pending_scans.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
